### sv/c3f_pkg.sv
// Shared constants and types of the 3x3 convolution filter.
package c3f_pkg;

	localparam int MAX_WIDTH_DEF    = 2048;
	localparam int MAX_CHANNELS_DEF = 4;
	localparam int FRAC_BITS_DEF    = 12;

	localparam int CHAN_W  = 8;
	localparam int COEFF_W = 16;
	localparam int ROW_W   = 3 * COEFF_W;
	localparam int TAPS    = 9;
	// Signed coefficient times a zero-extended sample, then a sum of nine of them.
	localparam int PROD_W  = COEFF_W + CHAN_W + 1;
	localparam int SUM_W   = PROD_W + 4;

	localparam int FW_W    = 12;
	localparam int FH_W    = 16;
	localparam int CC_W    = 3;
	localparam int CFG_A_W = 3;

	typedef enum logic [CFG_A_W-1:0] {
		REG_FRAME_WIDTH   = 3'd0,
		REG_FRAME_HEIGHT  = 3'd1,
		REG_CHANNEL_COUNT = 3'd2,
		REG_COEFF_TOP     = 3'd3,
		REG_COEFF_MID     = 3'd4,
		REG_COEFF_BOTTOM  = 3'd5,
		REG_RESULT_OFFSET = 3'd6
	} c3f_reg_t;

	localparam logic [FW_W-1:0]   FRAME_WIDTH_RST   = 12'd640;
	localparam logic [FH_W-1:0]   FRAME_HEIGHT_RST  = 16'd480;
	localparam logic [CC_W-1:0]   CHANNEL_COUNT_RST = 3'd1;
	localparam logic [ROW_W-1:0]  COEFF_SIDE_RST    = 48'd0;
	localparam logic [ROW_W-1:0]  COEFF_MID_RST     = 48'h0000_1000_0000;
	localparam logic [CHAN_W-1:0] RESULT_OFFSET_RST = 8'd0;
	localparam logic [CHAN_W-1:0] PIX_MAX           = 8'd255;

	// Control that travels with an item down the pipeline.
	typedef struct packed {
		logic pix;
		logic emit;
		logic filt;
		logic frame_end;
		logic sel_up;
	} c3f_ctl_t;

endpackage

### sv/c3f_in_if.sv
// Input pixel channel.
interface c3f_in_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] chan_a;
	logic [7:0] chan_b;
	logic [7:0] chan_c;
	logic [7:0] chan_d;
	modport source(output valid, action, chan_a, chan_b, chan_c, chan_d, input ready);
	modport sink(input valid, action, chan_a, chan_b, chan_c, chan_d, output ready);
endinterface

### sv/c3f_out_if.sv
// Output pixel channel.
interface c3f_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_a;
	logic [7:0] out_b;
	logic [7:0] out_c;
	logic [7:0] out_d;
	logic       frame_end;
	modport source(output valid, out_a, out_b, out_c, out_d, frame_end, input ready);
	modport sink(input valid, out_a, out_b, out_c, out_d, frame_end, output ready);
endinterface

### sv/c3f_cfg_if.sv
// Register write channel.
interface c3f_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  addr;
	logic [47:0] data;
	modport source(output valid, addr, data, input ready);
	modport sink(input valid, addr, data, output ready);
endinterface

### sv/conv3x3_filter.sv
// Top level of the 3x3 convolution filter over a raster pixel stream.
// Takes one beat per clock unless a result sits unaccepted at the output and
// gives at most one beat per clock. A pixel result leaves frame_width + 1
// input beats after its own pixel entered, through s1, s2, s3 .. s6 and the
// output register; drain beats flush what is still pending after the frame.
// The rate is set by the line stores, each with one read port and one write
// port and each read once and written at most once per beat, and by the lane
// pipeline, which is fully stalled only while a result sits unaccepted at the
// output. Line store contents are undefined after reset and need no clearing
// pass: only entries written by the current frame reach the output.
module conv3x3_filter #(
	parameter int MAX_WIDTH    = c3f_pkg::MAX_WIDTH_DEF,
	parameter int MAX_CHANNELS = c3f_pkg::MAX_CHANNELS_DEF,
	parameter int COEFF_FRAC_BITS = c3f_pkg::FRAC_BITS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	c3f_in_if.sink      pix_in,
	c3f_out_if.source   pix_out,
	c3f_cfg_if.sink     cfg
);
	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int PW    = $clog2(MAX_WIDTH + 2);
	localparam int CH_W  = c3f_pkg::CHAN_W;
	localparam int PIX_W = CH_W * MAX_CHANNELS;
	localparam int RW    = c3f_pkg::FH_W;
	localparam int NS    = 4; // control stages beside the lanes: s3 .. s6

	// Configuration
	logic [c3f_pkg::FW_W-1:0]  frame_width_q;
	logic [c3f_pkg::FH_W-1:0]  frame_height_q;
	logic [c3f_pkg::CC_W-1:0]  channel_count_q;
	logic [c3f_pkg::ROW_W-1:0] coeff_q [3];
	logic [CH_W-1:0]           result_offset_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q   <= c3f_pkg::FRAME_WIDTH_RST;
			frame_height_q  <= c3f_pkg::FRAME_HEIGHT_RST;
			channel_count_q <= c3f_pkg::CHANNEL_COUNT_RST;
			coeff_q[0]      <= c3f_pkg::COEFF_SIDE_RST;
			coeff_q[1]      <= c3f_pkg::COEFF_MID_RST;
			coeff_q[2]      <= c3f_pkg::COEFF_SIDE_RST;
			result_offset_q <= c3f_pkg::RESULT_OFFSET_RST;
		end else if (cfg.valid) begin
			case (c3f_pkg::c3f_reg_t'(cfg.addr))
				c3f_pkg::REG_FRAME_WIDTH:   frame_width_q   <= cfg.data[c3f_pkg::FW_W-1:0];
				c3f_pkg::REG_FRAME_HEIGHT:  frame_height_q  <= cfg.data[c3f_pkg::FH_W-1:0];
				c3f_pkg::REG_CHANNEL_COUNT: channel_count_q <= cfg.data[c3f_pkg::CC_W-1:0];
				c3f_pkg::REG_COEFF_TOP:     coeff_q[0]      <= cfg.data;
				c3f_pkg::REG_COEFF_MID:     coeff_q[1]      <= cfg.data;
				c3f_pkg::REG_COEFF_BOTTOM:  coeff_q[2]      <= cfg.data;
				c3f_pkg::REG_RESULT_OFFSET: result_offset_q <= cfg.data[CH_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective geometry
	logic [PW-1:0]          eff_w;
	logic [RW-1:0]          eff_h;
	logic [c3f_pkg::CC_W-1:0] eff_ch;

	always_comb begin
		if (frame_width_q == '0) begin
			eff_w = PW'(1);
		end else if (32'(frame_width_q) > 32'(MAX_WIDTH)) begin
			eff_w = PW'(MAX_WIDTH);
		end else begin
			eff_w = PW'(frame_width_q);
		end
		eff_h = (frame_height_q == '0) ? RW'(1) : frame_height_q;
		if (channel_count_q == '0) begin
			eff_ch = c3f_pkg::CC_W'(1);
		end else if (32'(channel_count_q) > 32'(MAX_CHANNELS)) begin
			eff_ch = c3f_pkg::CC_W'(MAX_CHANNELS);
		end else begin
			eff_ch = channel_count_q;
		end
	end

	// Position tracking and the emit decision at the accepting edge
	logic              out_valid_q;
	logic              adv;
	logic              acc;
	logic [CW-1:0]     in_col_q, out_col_q;
	logic [RW-1:0]     in_row_q, out_row_q;
	logic [PW-1:0]     pending_q;
	logic              enough;
	logic              in_last_col, in_last_row, out_last_col, out_last_row;
	logic              border;
	c3f_pkg::c3f_ctl_t ctl_in;
	logic [CW-1:0]     rd_addr;
	logic [PIX_W-1:0]  pix_word;
	logic [CH_W-1:0]   chans [4];

	assign adv          = !out_valid_q || pix_out.ready;
	assign pix_in.ready = adv;
	assign acc          = pix_in.valid && adv;

	assign chans[0] = pix_in.chan_a;
	assign chans[1] = pix_in.chan_b;
	assign chans[2] = pix_in.chan_c;
	assign chans[3] = pix_in.chan_d;
	for (genvar k = 0; k < MAX_CHANNELS; k++) begin : g_pack
		assign pix_word[k*CH_W +: CH_W] = chans[k];
	end

	assign enough       = {1'b0, pending_q} >= ({1'b0, eff_w} + (PW + 1)'(1));
	assign in_last_col  = ({1'b0, PW'(in_col_q)} + (PW + 1)'(1)) >= {1'b0, eff_w};
	assign in_last_row  = ({1'b0, in_row_q} + (RW + 1)'(1)) >= {1'b0, eff_h};
	assign out_last_col = ({1'b0, PW'(out_col_q)} + (PW + 1)'(1)) >= {1'b0, eff_w};
	assign out_last_row = ({1'b0, out_row_q} + (RW + 1)'(1)) >= {1'b0, eff_h};
	assign border       = (out_row_q == '0) || (out_col_q == '0) || out_last_row || out_last_col;

	always_comb begin
		ctl_in.pix       = !pix_in.action;
		ctl_in.emit      = pix_in.action ? (pending_q != '0) : enough;
		ctl_in.filt      = !pix_in.action && !border;
		ctl_in.frame_end = out_last_row && out_last_col;
		ctl_in.sel_up    = enough;
		rd_addr          = pix_in.action ? out_col_q : in_col_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			pending_q <= '0;
		end else if (acc) begin
			if (ctl_in.pix) begin
				in_col_q <= in_last_col ? '0 : in_col_q + CW'(1);
				if (in_last_col) begin
					in_row_q <= in_last_row ? '0 : in_row_q + RW'(1);
				end
				if (!enough) begin
					pending_q <= pending_q + PW'(1);
				end
			end else if (ctl_in.emit) begin
				pending_q <= pending_q - PW'(1);
			end
			if (ctl_in.emit) begin
				out_col_q <= out_last_col ? '0 : out_col_q + CW'(1);
				if (out_last_col) begin
					out_row_q <= out_last_row ? '0 : out_row_q + RW'(1);
				end
			end
		end
	end

	// Stage 1: line store read; the upper store is written from the stage 1 registers when the pipeline advances.
	logic              v_s1;
	c3f_pkg::c3f_ctl_t ctl_s1;
	logic [CW-1:0]     col_s1;
	logic [PIX_W-1:0]  pix_s1;
	logic              byp_s1;
	logic [PIX_W-1:0]  byp_val_s1;
	logic [PIX_W-1:0]  rd_up, rd_lo, up_eff;

	c3f_line_buf #(
		.MAX_WIDTH (MAX_WIDTH),
		.PIX_W     (PIX_W)
	) u_line_buf (
		.clk     (clk),
		.rd_en   (acc),
		.rd_addr (rd_addr),
		.rd_up   (rd_up),
		.rd_lo   (rd_lo),
		.lo_we   (acc && ctl_in.pix),
		.lo_addr (in_col_q),
		.lo_data (pix_word),
		.up_we   (adv && v_s1 && ctl_s1.pix),
		.up_addr (col_s1),
		.up_data (rd_lo)
	);

	// A read of the column whose upper entry is written at the same edge takes
	// the value being written.
	assign up_eff = byp_s1 ? byp_val_s1 : rd_up;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			byp_s1 <= 1'b0;
		end else if (adv) begin
			v_s1   <= acc;
			byp_s1 <= acc && v_s1 && ctl_s1.pix && (col_s1 == rd_addr);
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			ctl_s1     <= ctl_in;
			col_s1     <= rd_addr;
			pix_s1     <= pix_word;
			byp_val_s1 <= rd_lo;
		end
	end

	// Stage 2: window shift
	logic [PIX_W-1:0]  win_q [c3f_pkg::TAPS];
	logic              v_s2;
	c3f_pkg::c3f_ctl_t ctl_s2;
	logic [PIX_W-1:0]  pass_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < c3f_pkg::TAPS; i++) begin
				win_q[i] <= '0;
			end
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
			if (v_s1 && ctl_s1.pix) begin
				for (int r = 0; r < 3; r++) begin
					win_q[r*3]     <= win_q[r*3 + 1];
					win_q[r*3 + 1] <= win_q[r*3 + 2];
				end
				win_q[2] <= up_eff;
				win_q[5] <= rd_lo;
				win_q[8] <= pix_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s2 <= ctl_s1;
			if (ctl_s1.pix) begin
				pass_s2 <= win_q[5];
			end else begin
				pass_s2 <= ctl_s1.sel_up ? up_eff : rd_lo;
			end
		end
	end

	// Lanes, one per channel
	logic [CH_W-1:0] lane_res [MAX_CHANNELS];

	for (genvar k = 0; k < MAX_CHANNELS; k++) begin : g_lane
		logic [CH_W-1:0] px [c3f_pkg::TAPS];
		for (genvar i = 0; i < c3f_pkg::TAPS; i++) begin : g_px
			assign px[i] = win_q[i][k*CH_W +: CH_W];
		end
		c3f_lane #(
			.FRAC_BITS (COEFF_FRAC_BITS)
		) u_lane (
			.clk    (clk),
			.en     (adv),
			.px     (px),
			.rows   (coeff_q),
			.offset (result_offset_q),
			.res    (lane_res[k])
		);
	end

	// Control travels beside the lanes through s3 .. s6.
	logic              v_d   [NS];
	c3f_pkg::c3f_ctl_t ctl_d [NS];
	logic [PIX_W-1:0]  pass_d [NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NS; i++) begin
				v_d[i] <= 1'b0;
			end
		end else if (adv) begin
			v_d[0] <= v_s2;
			for (int i = 1; i < NS; i++) begin
				v_d[i] <= v_d[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_d[0]  <= ctl_s2;
			pass_d[0] <= pass_s2;
			for (int i = 1; i < NS; i++) begin
				ctl_d[i]  <= ctl_d[i-1];
				pass_d[i] <= pass_d[i-1];
			end
		end
	end

	// Merge: pick filtered or passed-through channels into the output register; unused ones are zero.
	logic [CH_W-1:0] out_q [4];
	logic            frame_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_d[NS-1] && ctl_d[NS-1].emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			frame_end_q <= ctl_d[NS-1].frame_end;
			for (int k = 0; k < MAX_CHANNELS; k++) begin
				if (32'(k) < 32'(eff_ch)) begin
					out_q[k] <= ctl_d[NS-1].filt ? lane_res[k] : pass_d[NS-1][k*CH_W +: CH_W];
				end else begin
					out_q[k] <= '0;
				end
			end
			for (int k = MAX_CHANNELS; k < 4; k++) begin
				out_q[k] <= '0;
			end
		end
	end

	assign pix_out.valid     = out_valid_q;
	assign pix_out.out_a     = out_q[0];
	assign pix_out.out_b     = out_q[1];
	assign pix_out.out_c     = out_q[2];
	assign pix_out.out_d     = out_q[3];
	assign pix_out.frame_end = frame_end_q;
endmodule

### sv/c3f_line_buf.sv
// Two line stores with registered reads at one shared column.
module c3f_line_buf #(
	parameter int MAX_WIDTH = c3f_pkg::MAX_WIDTH_DEF,
	parameter int PIX_W     = 32
) (
	input  logic                         clk,
	input  logic                         rd_en,
	input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
	output logic [PIX_W-1:0]             rd_up,
	output logic [PIX_W-1:0]             rd_lo,
	input  logic                         lo_we,
	input  logic [$clog2(MAX_WIDTH)-1:0] lo_addr,
	input  logic [PIX_W-1:0]             lo_data,
	input  logic                         up_we,
	input  logic [$clog2(MAX_WIDTH)-1:0] up_addr,
	input  logic [PIX_W-1:0]             up_data
);
	logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
	logic [PIX_W-1:0] lower_mem [MAX_WIDTH];
	logic [PIX_W-1:0] rd_up_q;
	logic [PIX_W-1:0] rd_lo_q;

	always_ff @(posedge clk) begin
		if (up_we) begin
			upper_mem[up_addr] <= up_data;
		end
		if (rd_en) begin
			rd_up_q <= upper_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (lo_we) begin
			lower_mem[lo_addr] <= lo_data;
		end
		if (rd_en) begin
			rd_lo_q <= lower_mem[rd_addr];
		end
	end

	assign rd_up = rd_up_q;
	assign rd_lo = rd_lo_q;
endmodule

### sv/c3f_lane.sv
// One channel of the 3x3 multiply-accumulate with rounding, offset and clamp.
module c3f_lane #(
	parameter int FRAC_BITS = c3f_pkg::FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic [c3f_pkg::CHAN_W-1:0]  px [c3f_pkg::TAPS],
	input  logic [c3f_pkg::ROW_W-1:0]   rows [3],
	input  logic [c3f_pkg::CHAN_W-1:0]  offset,
	output logic [c3f_pkg::CHAN_W-1:0]  res
);
	localparam int SW = c3f_pkg::SUM_W;
	localparam logic [SW-1:0] HALF = SW'(1) << (FRAC_BITS - 1);

	logic signed [c3f_pkg::PROD_W-1:0] prod_s3 [c3f_pkg::TAPS];
	logic signed [SW-1:0]              sum;
	logic signed [SW-1:0]              sum_s4;
	logic        [SW-1:0]              mag;
	logic                              neg_s5;
	logic        [SW-1:0]              rq_s5;
	logic signed [SW:0]                q;
	logic signed [SW:0]                qo;
	logic        [c3f_pkg::CHAN_W-1:0] res_s6;

	for (genvar i = 0; i < c3f_pkg::TAPS; i++) begin : g_tap
		logic signed [c3f_pkg::COEFF_W-1:0] coef;
		assign coef = rows[i / 3][(i % 3) * c3f_pkg::COEFF_W +: c3f_pkg::COEFF_W];
		always_ff @(posedge clk) begin
			if (en) begin
				prod_s3[i] <= c3f_pkg::PROD_W'(coef * $signed({1'b0, px[i]}));
			end
		end
	end

	always_comb begin
		sum = '0;
		for (int i = 0; i < c3f_pkg::TAPS; i++) begin
			sum = sum + SW'(prod_s3[i]);
		end
	end

	// Rounding works on the magnitude so that halves go away from zero.
	assign mag = sum_s4[SW-1] ? SW'(-sum_s4) : SW'(sum_s4);
	assign q   = neg_s5 ? -$signed({1'b0, rq_s5}) : $signed({1'b0, rq_s5});
	assign qo  = q + $signed({{(SW + 1 - c3f_pkg::CHAN_W){1'b0}}, offset});

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s4 <= sum;
			neg_s5 <= sum_s4[SW-1];
			rq_s5  <= (mag + HALF) >> FRAC_BITS;
			if (qo < 0) begin
				res_s6 <= '0;
			end else if (qo > $signed({{(SW + 1 - c3f_pkg::CHAN_W){1'b0}}, c3f_pkg::PIX_MAX}))
			begin
				res_s6 <= c3f_pkg::PIX_MAX;
			end else begin
				res_s6 <= qo[c3f_pkg::CHAN_W-1:0];
			end
		end
	end

	assign res = res_s6;
endmodule
